>>> sv/lft_pkg.sv
package lft_pkg;

  localparam logic [7:0] CODE_BASEMENT = 8'he0;
  localparam logic [3:0] BASE_TICKS    = 4'd10;
  localparam logic [1:0] CLEAR_TICKS   = 2'd2;

  localparam logic [7:0] TOP_FLOOR_RESET    = 8'd32;
  localparam logic [7:0] BOTTOM_DEPTH_RESET = 8'd3;
  localparam logic [7:0] BASE_FLOOR_RESET   = 8'd1;

  localparam logic [1:0] CFG_TOP_FLOOR    = 2'd0;
  localparam logic [1:0] CFG_BOTTOM_DEPTH = 2'd1;
  localparam logic [1:0] CFG_BASE_FLOOR   = 2'd2;

  localparam logic [2:0] STEP_WAIT_LEVEL   = 3'd0;
  localparam logic [2:0] STEP_WAIT_DEPART  = 3'd1;
  localparam logic [2:0] STEP_CLEAR_A      = 3'd2;
  localparam logic [2:0] STEP_CLEAR_B      = 3'd3;
  localparam logic [2:0] STEP_UP_ENTRY     = 3'd4;
  localparam logic [2:0] STEP_UP_LEVEL     = 3'd5;
  localparam logic [2:0] STEP_DOWN_ENTRY   = 3'd6;
  localparam logic [2:0] STEP_DOWN_LEVEL   = 3'd7;

  typedef struct packed {
    logic              base_found;
    logic [3:0]        base_count;
    logic [2:0]        track_step;
    logic [1:0]        leave_count;
    logic signed [8:0] floor_position;
    logic [7:0]        shown_code;
    logic [1:0]        direction_bits;
    logic [1:0]        overtravel_bits;
  } lft_state_t;

  function automatic logic [7:0] code_of(input logic signed [8:0] fp);
    logic [8:0] neg;
    neg = 9'(-fp);
    if (fp >= 0) begin
      code_of = fp[7:0];
    end else begin
      code_of = CODE_BASEMENT + neg[7:0];
    end
  endfunction

endpackage

>>> sv/lift_floor_tracker.sv
// an accepted item waits in the input register until the result register takes it
// throughput: one item per cycle while the result side does not stall
// the floor state is updated in a single pass of lft_core
// reset (rst, synchronous, active high): empties both stages, clears the tracking state
// and loads top_floor 32, bottom_depth 3 and base_floor 1
module lift_floor_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              upper_sensor,
  input  logic              lower_sensor,
  input  logic              base_pin,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] floor_number,
  output logic [7:0]        display_code,
  output logic              moving_up,
  output logic              moving_down,
  output logic              top_overtravel,
  output logic              bottom_overtravel,
  output logic              base_known,
  output logic              base_lamp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import lft_pkg::*;

  logic [7:0] top_floor;
  logic [7:0] bottom_depth;
  logic [7:0] base_floor;

  logic s_valid;
  logic s_up;
  logic s_dn;
  logic s_base;

  lft_state_t st;
  lft_state_t st_next;
  logic       lamp_next;

  logic out_take;
  logic s_adv;
  logic accept;

  assign cfg_ready = 1'b1;
  assign out_take  = !out_valid || !out_stall;
  assign s_adv     = s_valid && out_take;
  assign in_stall  = s_valid && !out_take;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor    <= TOP_FLOOR_RESET;
      bottom_depth <= BOTTOM_DEPTH_RESET;
      base_floor   <= BASE_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOP_FLOOR:    top_floor    <= cfg_data;
        CFG_BOTTOM_DEPTH: bottom_depth <= cfg_data;
        CFG_BASE_FLOOR:   base_floor   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (s_adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_up   <= upper_sensor;
      s_dn   <= lower_sensor;
      s_base <= base_pin;
    end
  end

  lft_core u_core (
    .st           (st),
    .top_floor    (top_floor),
    .bottom_depth (bottom_depth),
    .base_floor   (base_floor),
    .upper_sensor (s_up),
    .lower_sensor (s_dn),
    .base_pin     (s_base),
    .st_next      (st_next),
    .lamp         (lamp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      floor_number      <= st_next.floor_position;
      display_code      <= st_next.shown_code;
      moving_up         <= st_next.direction_bits[0];
      moving_down       <= st_next.direction_bits[1];
      top_overtravel    <= st_next.overtravel_bits[0];
      bottom_overtravel <= st_next.overtravel_bits[1];
      base_known        <= st_next.base_found;
      base_lamp         <= lamp_next;
    end
  end

  a_track_idle_until_base: assert property (@(posedge clk) disable iff (rst)
    !st.base_found |-> st.track_step == STEP_WAIT_LEVEL)
    else $error("tracking left its idle step before the base was found");

  a_count_clear_after_base: assert property (@(posedge clk) disable iff (rst)
    st.base_found |-> st.base_count == 4'd0)
    else $error("base tick count not cleared once tracking is active");

  a_leave_count_scope: assert property (@(posedge clk) disable iff (rst)
    (st.track_step != STEP_CLEAR_A && st.track_step != STEP_CLEAR_B)
      |-> st.leave_count == 2'd0)
    else $error("all-clear count held outside the debounce steps");

  a_direction_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(moving_up && moving_down))
    else $error("both direction flags set");

  a_lamp_needs_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_lamp |-> base_known)
    else $error("base lamp lit before the base was found");

endmodule

>>> sv/lft_core.sv
module lft_core (
  input  lft_pkg::lft_state_t st,
  input  logic [7:0]          top_floor,
  input  logic [7:0]          bottom_depth,
  input  logic [7:0]          base_floor,
  input  logic                upper_sensor,
  input  logic                lower_sensor,
  input  logic                base_pin,
  output lft_pkg::lft_state_t st_next,
  output logic                lamp
);
  import lft_pkg::*;

  logic level;
  logic all_clear;
  logic up_only;
  logic dn_only;
  logic base_low;

  assign level     = upper_sensor && lower_sensor;
  assign all_clear = !upper_sensor && !lower_sensor;
  assign up_only   = upper_sensor && !lower_sensor;
  assign dn_only   = !upper_sensor && lower_sensor;
  assign base_low  = !base_pin;

  always_comb begin
    lft_state_t        n;
    logic signed [9:0] fp_w;
    logic [8:0]        neg;
    logic [1:0]        lc_w;
    n    = st;
    lamp = 1'b0;
    fp_w = '0;
    neg  = '0;
    lc_w = '0;

    // base step
    if (!st.base_found) begin
      if (base_low) begin
        n.base_count = st.base_count + 4'd1;
        if (n.base_count >= BASE_TICKS) begin
          n.base_found     = 1'b1;
          n.floor_position = 9'(signed'({1'b0, base_floor}));
          n.base_count     = '0;
        end
      end else begin
        n.base_count = '0;
      end
    end else if (base_low) begin
      lamp             = 1'b1;
      n.floor_position = 9'(signed'({1'b0, base_floor}));
      n.shown_code     = code_of(n.floor_position);
    end

    neg = 9'(-n.floor_position);

    // tracking step
    if (n.base_found) begin
      case (n.track_step)
        STEP_WAIT_LEVEL: begin
          if (level) begin
            n.track_step      = STEP_WAIT_DEPART;
            n.overtravel_bits = '0;
          end
        end
        STEP_WAIT_DEPART: begin
          if (dn_only) begin
            n.track_step     = STEP_CLEAR_A;
            n.direction_bits = 2'b01;
            lamp             = 1'b0;
            if (n.floor_position > 0 && n.floor_position[7:0] == top_floor) begin
              n.overtravel_bits[0] = 1'b1;
            end
          end else if (up_only) begin
            n.track_step     = STEP_CLEAR_B;
            n.direction_bits = 2'b10;
            lamp             = 1'b0;
            if (n.floor_position < 0 && neg[7:0] == bottom_depth) begin
              n.overtravel_bits[1] = 1'b1;
            end
          end
        end
        STEP_CLEAR_A, STEP_CLEAR_B: begin
          if (all_clear) begin
            lc_w = n.leave_count + 2'd1;
            n.leave_count = lc_w;
            if (lc_w > CLEAR_TICKS) begin
              n.leave_count = '0;
              n.track_step  = (n.track_step == STEP_CLEAR_A) ? STEP_UP_ENTRY
                                                             : STEP_DOWN_ENTRY;
            end
          end else begin
            n.leave_count = '0;
          end
        end
        STEP_UP_ENTRY: begin
          if (up_only) begin
            n.track_step = STEP_UP_LEVEL;
          end else if (dn_only) begin
            n.track_step = STEP_WAIT_LEVEL;
          end
        end
        STEP_UP_LEVEL: begin
          if (level) begin
            fp_w = 10'(n.floor_position) + 10'sd1;
            if (fp_w > 0 && fp_w > signed'({2'b00, top_floor})) begin
              fp_w = signed'({2'b00, top_floor});
            end
            if (fp_w == 0) begin
              fp_w = 10'sd1;
            end
            n.floor_position     = fp_w[8:0];
            n.shown_code         = code_of(n.floor_position);
            n.track_step         = STEP_WAIT_LEVEL;
            n.overtravel_bits[0] = 1'b0;
          end else if (all_clear) begin
            n.track_step = STEP_WAIT_LEVEL;
          end
        end
        STEP_DOWN_ENTRY: begin
          if (dn_only) begin
            n.track_step = STEP_DOWN_LEVEL;
          end else if (up_only) begin
            n.track_step = STEP_WAIT_LEVEL;
          end
        end
        default: begin
          if (level) begin
            fp_w = 10'(n.floor_position);
            if (n.floor_position > 0) begin
              fp_w = fp_w - 10'sd1;
            end else if (n.floor_position < 0 && neg[7:0] < bottom_depth) begin
              fp_w = fp_w - 10'sd1;
            end
            if (fp_w == 0) begin
              fp_w = -10'sd1;
            end
            n.floor_position     = fp_w[8:0];
            n.shown_code         = code_of(n.floor_position);
            n.track_step         = STEP_WAIT_LEVEL;
            n.overtravel_bits[1] = 1'b0;
          end else if (all_clear) begin
            n.track_step = STEP_WAIT_LEVEL;
          end
        end
      endcase
    end

    st_next = n;
  end

endmodule
